// File: hdl/crlf_rx_pkg.sv
// Package for the CR LF line receiver: item kinds, line characters,
// field widths and the framing phase type. No dependencies.
`default_nettype none

package crlf_rx_pkg;

    // Field widths of the item and result channels.
    localparam int KIND_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int LEN_W   = 7;

    // Default message capacity in bytes, CR included; the LF may take one more.
    localparam int MAX_LEN_DEFAULT = 63;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

    // Line characters.
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_BODY    = 2'd1,
        PH_WAIT_LF = 2'd2
    } phase_t;

endpackage

`default_nettype wire

// File: hdl/crlf_rx_if.sv
// Valid/ready channel interfaces for the CR LF line receiver items and results.
// Depends on crlf_rx_pkg for the field widths.
`default_nettype none

interface crlf_rx_item_if;
    logic                               valid;
    logic                               ready;
    logic [crlf_rx_pkg::KIND_W-1:0]     kind;
    logic [crlf_rx_pkg::BYTE_W-1:0]     data_byte;
    logic [crlf_rx_pkg::INDEX_W-1:0]    read_index;

    modport source (output valid, output kind, output data_byte, output read_index,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input read_index,
                    output ready);
endinterface

interface crlf_rx_result_if;
    logic                               valid;
    logic                               ready;
    logic                               message_ready;
    logic [crlf_rx_pkg::LEN_W-1:0]      message_length;
    logic [crlf_rx_pkg::BYTE_W-1:0]     read_data;

    modport source (output valid, output message_ready, output message_length,
                    output read_data, input ready);
    modport sink   (input valid, input message_ready, input message_length,
                    input read_data, output ready);
endinterface

`default_nettype wire

// File: hdl/crlf_line_receiver.sv
// CR LF line receiver: result valid rises in the cycle after item transfer.
// Stall aside, 1 item per cycle; the item register and the buffer read port
// both take one transfer a cycle. Reset clears the phase, ready flag, length
// and result valid at once; the line buffer is not cleared and needs no pass.
// Depends on crlf_rx_pkg, crlf_rx_if, crlf_rx_ctrl and crlf_rx_ram.
`default_nettype none

module crlf_line_receiver #(
    parameter int MAX_LEN = crlf_rx_pkg::MAX_LEN_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    crlf_rx_item_if.sink    item,
    crlf_rx_result_if.source result
);

    // The buffer holds MAX_LEN bytes plus one, so an overlong message stops
    // at MAX_LEN + 1 stored bytes. The length counter must hold that value.
    localparam int DEPTH = MAX_LEN + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(MAX_LEN + 2);
    localparam int OW    = (LW > crlf_rx_pkg::LEN_W) ? LW : crlf_rx_pkg::LEN_W;

    logic                               accept;
    logic                               valid_reg;
    logic                               valid_next;
    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    logic [AW-1:0]                      rd_addr;
    logic                               rd_hit_reg;
    logic                               ready_flag_reg;
    logic [LW-1:0]                      length_reg;
    logic [OW-1:0]                      length_wide;
    logic [crlf_rx_pkg::BYTE_W-1:0]     rd_data;

    // A new item is taken whenever the result slot is empty or is being
    // drained in the same cycle. While a result is stalled nothing is
    // accepted, so the state registers and the buffer read register hold
    // exactly the values that belong to the pending result.
    assign item.ready = !valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    crlf_rx_ctrl #(
        .MAX_LEN (MAX_LEN),
        .DEPTH   (DEPTH),
        .AW      (AW),
        .LW      (LW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .kind           (item.kind),
        .data_byte      (item.data_byte),
        .read_index     (item.read_index),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .rd_addr        (rd_addr),
        .rd_hit_reg     (rd_hit_reg),
        .ready_flag_reg (ready_flag_reg),
        .length_reg     (length_reg)
    );

    // Every item reads the buffer, only reads use it, and a byte written on
    // one transfer is visible to a read on the next.
    crlf_rx_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (crlf_rx_pkg::BYTE_W)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (item.data_byte),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // The reported length is the stored length cut to the field width.
    assign length_wide = OW'(length_reg);

    assign result.valid          = valid_reg;
    assign result.message_ready  = ready_flag_reg;
    assign result.message_length = length_wide[crlf_rx_pkg::LEN_W-1:0];
    // Positions beyond the stored length, and items that are not reads,
    // return zero.
    assign result.read_data      = rd_hit_reg ? rd_data : '0;

endmodule

`default_nettype wire

// File: hdl/crlf_rx_ram.sv
// Line buffer memory: one write port, one read port with registered read data.
// No package dependencies.
`default_nettype none

module crlf_rx_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/crlf_rx_ctrl.sv
// Framing control: phase, ready flag and stored length, buffer write and read hit.
// Depends on crlf_rx_pkg.
`default_nettype none

module crlf_rx_ctrl #(
    parameter int MAX_LEN = crlf_rx_pkg::MAX_LEN_DEFAULT,
    parameter int DEPTH   = MAX_LEN + 1,
    parameter int AW      = $clog2(DEPTH),
    parameter int LW      = $clog2(MAX_LEN + 2)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               accept,
    input  wire logic [crlf_rx_pkg::KIND_W-1:0]     kind,
    input  wire logic [crlf_rx_pkg::BYTE_W-1:0]     data_byte,
    input  wire logic [crlf_rx_pkg::INDEX_W-1:0]    read_index,
    output logic                                    wr_en,
    output logic      [AW-1:0]                      wr_addr,
    output logic      [AW-1:0]                      rd_addr,
    output logic                                    rd_hit_reg,
    output logic                                    ready_flag_reg,
    output logic      [LW-1:0]                      length_reg
);

    // Compare width wide enough for both the read index and the length.
    localparam int CW = (LW > crlf_rx_pkg::INDEX_W) ? LW : crlf_rx_pkg::INDEX_W;

    crlf_rx_pkg::phase_t phase_reg;
    crlf_rx_pkg::phase_t phase_next;
    logic                ready_flag_next;
    logic [LW-1:0]       length_next;
    logic                rd_hit_next;
    logic [CW-1:0]       index_ext;
    logic [CW-1:0]       length_ext;
    logic                has_room;

    assign has_room   = length_reg < LW'(DEPTH);
    assign index_ext  = CW'(read_index);
    assign length_ext = CW'(length_reg);
    assign rd_addr    = index_ext[AW-1:0];

    always_comb
    begin
        phase_next      = phase_reg;
        ready_flag_next = ready_flag_reg;
        length_next     = length_reg;
        rd_hit_next     = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = length_reg[AW-1:0];

        if (accept)
        begin
            unique case (kind)
                crlf_rx_pkg::KIND_BYTE:
                begin
                    if (!ready_flag_reg)
                    begin
                        unique case (phase_reg)
                            crlf_rx_pkg::PH_IDLE:
                            begin
                                // Any byte opens a new message at position zero.
                                wr_en       = 1'b1;
                                wr_addr     = '0;
                                length_next = LW'(1);
                                phase_next  = crlf_rx_pkg::PH_BODY;
                            end
                            crlf_rx_pkg::PH_BODY:
                            begin
                                if (has_room)
                                begin
                                    wr_en       = 1'b1;
                                    length_next = length_reg + LW'(1);
                                end
                                if (data_byte == crlf_rx_pkg::CHAR_CR)
                                begin
                                    phase_next = crlf_rx_pkg::PH_WAIT_LF;
                                end
                                // An overlong message is abandoned.
                                if (length_next > LW'(MAX_LEN))
                                begin
                                    phase_next = crlf_rx_pkg::PH_IDLE;
                                end
                            end
                            crlf_rx_pkg::PH_WAIT_LF:
                            begin
                                if (data_byte == crlf_rx_pkg::CHAR_LF)
                                begin
                                    if (has_room)
                                    begin
                                        wr_en       = 1'b1;
                                        length_next = length_reg + LW'(1);
                                    end
                                    ready_flag_next = 1'b1;
                                end
                                phase_next = crlf_rx_pkg::PH_IDLE;
                            end
                            default:
                            begin
                                phase_next = crlf_rx_pkg::PH_IDLE;
                            end
                        endcase
                    end
                end
                crlf_rx_pkg::KIND_RELEASE:
                begin
                    ready_flag_next = 1'b0;
                end
                crlf_rx_pkg::KIND_READ:
                begin
                    rd_hit_next = (index_ext < length_ext) && (index_ext < CW'(DEPTH));
                end
                default:
                begin
                    rd_hit_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= crlf_rx_pkg::PH_IDLE;
            ready_flag_reg <= 1'b0;
            length_reg     <= '0;
            rd_hit_reg     <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            ready_flag_reg <= ready_flag_next;
            length_reg     <= length_next;
            if (accept)
            begin
                rd_hit_reg <= rd_hit_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench for crlf_line_receiver: directed and random item streams checked
// against a line framing predictor kept in a small scoreboard class.
// Depends on crlf_rx_pkg, crlf_rx_if and the crlf_line_receiver RTL.

module tb;

    import crlf_rx_pkg::*;

    // Timing and run shape.
    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int LATENCY       = 1;
    localparam int SETTLE_CYCLES = LATENCY + 7;
    localparam int HOLD_CYCLES   = 120;
    localparam int QUIET_LIMIT   = 2000;
    localparam int ITEM_TARGET   = 1750;

    // Message capacity of the instance; the buffer holds one entry more.
    localparam int CAPACITY = MAX_LEN_DEFAULT;
    localparam int DEPTH    = CAPACITY + 1;

    // The one kind code that the block defines no action for.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // What one result transfer is expected to carry.
    typedef struct packed {
        logic               msg_ready;
        logic [LEN_W-1:0]   msg_length;
        logic [BYTE_W-1:0]  data;
    } line_status_t;

    // Tracks the framer state, predicts the status for each accepted item and
    // checks the results in order against those predictions.
    class line_framer_tracker;
        phase_t             state;
        bit                 held;
        int unsigned        length;
        logic [BYTE_W-1:0]  line_mem [DEPTH];
        line_status_t       pending_status [$];
        int                 errors;
        int                 lines_framed;
        int                 dropped_after_cr;
        int                 overlong_lines;
        int                 reads_checked;

        function new();
            state  = PH_IDLE;
            held   = 1'b0;
            length = 0;
            errors = 0;
        endfunction

        function void append(logic [BYTE_W-1:0] b);
            if (length < DEPTH)
            begin
                line_mem[length] = b;
                length++;
            end
        endfunction

        function void absorb(logic [BYTE_W-1:0] b);
            case (state)
                PH_IDLE:
                begin
                    length = 0;
                    append(b);
                    state = PH_BODY;
                end
                PH_BODY:
                begin
                    append(b);
                    if (b == CHAR_CR)
                        state = PH_WAIT_LF;
                    if (length > CAPACITY)
                    begin
                        state = PH_IDLE;
                        overlong_lines++;
                    end
                end
                PH_WAIT_LF:
                begin
                    if (b == CHAR_LF)
                    begin
                        append(b);
                        held = 1'b1;
                        lines_framed++;
                    end
                    else
                        dropped_after_cr++;
                    state = PH_IDLE;
                end
                default:
                    state = PH_IDLE;
            endcase
        endfunction

        // Notes an accepted item; returns 0 when the block merely ignores it.
        function bit note_item(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] b,
                               logic [INDEX_W-1:0] ix);
            line_status_t st;
            bit           useful;
            useful = 1'b1;
            st.data = '0;
            case (k)
                KIND_BYTE:
                    if (held)
                        useful = 1'b0;
                    else
                        absorb(b);
                KIND_RELEASE:
                begin
                    useful = held;
                    held = 1'b0;
                end
                KIND_READ:
                begin
                    reads_checked++;
                    if (ix < length)
                        st.data = line_mem[ix];
                end
                default:
                    useful = 1'b0;
            endcase
            st.msg_ready  = held;
            st.msg_length = length[LEN_W-1:0];
            pending_status.push_back(st);
            return useful;
        endfunction

        function void check_result(logic mr, logic [LEN_W-1:0] ml, logic [BYTE_W-1:0] rd);
            line_status_t want;
            if (pending_status.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result: ready %0b length %0d data %02h",
                         $time, mr, ml, rd);
                return;
            end
            want = pending_status.pop_front();
            if (mr !== want.msg_ready)
            begin
                errors++;
                $display("%0t ns: message_ready expected %0b actual %0b",
                         $time, want.msg_ready, mr);
            end
            if (ml !== want.msg_length)
            begin
                errors++;
                $display("%0t ns: message_length expected %0d actual %0d",
                         $time, want.msg_length, ml);
            end
            if (rd !== want.data)
            begin
                errors++;
                $display("%0t ns: read_data expected %02h actual %02h",
                         $time, want.data, rd);
            end
        endfunction

        function int pending();
            return pending_status.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    crlf_rx_item_if   item_ch ();
    crlf_rx_result_if result_ch ();

    crlf_line_receiver u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    line_framer_tracker framer = new();

    // Idle percentages of the two sides; the main sequence changes them per phase.
    int send_idle_pct = 31;
    int recv_idle_pct = 51;

    // Set by the main sequence to ask the receiver for one long hold-off.
    bit hold_request = 1'b0;

    int accepted_items = 0;
    int useful_items   = 0;
    int quiet_cycles   = 0;

    initial
    begin
        clk = 1'b0;
        forever
            #HALF_PERIOD clk = ~clk;
    end

    // Result side: ready goes low at random, or for a whole stretch when a
    // hold-off is asked for. The stretch is counted here, so the sender keeps
    // offering items and the block has to fill up and stall its input.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every result transfer is checked against the oldest prediction. Values
    // are read right at the edge, before any register of that edge updates.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            framer.check_result(result_ch.message_ready, result_ch.message_length,
                                result_ch.read_data);
    end

    // The watchdog ends the run when no transfer happens on either side for
    // far longer than the longest hold-off or random gap could explain.
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, framer.pending());
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offers one item, after a random number of idle cycles, and returns at
    // the edge where it is accepted. Valid stays high into the next item
    // when no idle cycle comes between them.
    task automatic send_item(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b,
                             input logic [INDEX_W-1:0] ix);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.kind       <= k;
        item_ch.data_byte  <= b;
        item_ch.read_index <= ix;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        accepted_items++;
        if (framer.note_item(k, b, ix))
            useful_items++;
    endtask

    // The unused field of each kind carries random bits so that every bit
    // of every input field is exercised.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_item(KIND_BYTE, b, INDEX_W'($urandom));
    endtask

    task automatic send_read(input logic [INDEX_W-1:0] ix);
        send_item(KIND_READ, BYTE_W'($urandom), ix);
    endtask

    task automatic send_release();
        send_item(KIND_RELEASE, BYTE_W'($urandom), INDEX_W'($urandom));
    endtask

    // Drops valid and waits until the block has returned every result.
    task automatic pause_until_drained();
        item_ch.valid <= 1'b0;
        while (framer.pending() != 0)
            @(posedge clk);
    endtask

    // A body byte never ends the line early.
    function automatic logic [BYTE_W-1:0] body_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom);
        while (b == CHAR_CR)
            b = BYTE_W'($urandom);
        return b;
    endfunction

    // Mostly short lines, some medium, a few near the capacity.
    function automatic int line_body_len();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return $urandom_range(0, 8);
        else if (pick < 92)
            return $urandom_range(9, 40);
        return $urandom_range(CAPACITY - 8, CAPACITY - 1);
    endfunction

    // Sends a body and a CR, then either the LF or some other byte, which
    // the block drops before going back to idle.
    task automatic send_line(input int body_len, input bit with_lf);
        logic [BYTE_W-1:0] tail;
        if (framer.held)
            send_release();
        for (int i = 0; i < body_len; i++)
            send_byte(body_byte());
        send_byte(CHAR_CR);
        if (with_lf)
            send_byte(CHAR_LF);
        else
        begin
            tail = BYTE_W'($urandom);
            while (tail == CHAR_LF)
                tail = BYTE_W'($urandom);
            send_byte(tail);
        end
    endtask

    // Reads part of the held message, mostly inside its length, sometimes
    // pushes bytes that must be ignored, then usually releases it.
    task automatic read_back_and_release();
        int reads;
        reads = $urandom_range(0, 4);
        repeat (reads)
        begin
            if (framer.length > 0 && $urandom_range(99) < 80)
                send_read(INDEX_W'($urandom_range(framer.length - 1)));
            else
                send_read(INDEX_W'($urandom));
        end
        if ($urandom_range(99) < 25)
            repeat ($urandom_range(1, 2)) send_byte(BYTE_W'($urandom));
        if ($urandom_range(99) < 90)
            send_release();
        if ($urandom_range(99) < 10)
            send_release();
    endtask

    // A few items of any kind, with CR and LF frequent among the bytes.
    task automatic noise_burst();
        int                count;
        logic [KIND_W-1:0] k;
        logic [BYTE_W-1:0] b;
        count = $urandom_range(1, 6);
        repeat (count)
        begin
            if ($urandom_range(15) == 0)
                k = KIND_UNUSED;
            else
                k = KIND_W'($urandom_range(2));
            case ($urandom_range(3))
                0:       b = CHAR_CR;
                1:       b = CHAR_LF;
                default: b = BYTE_W'($urandom);
            endcase
            send_item(k, b, INDEX_W'($urandom));
        end
    endtask

    // One random sequence: mostly complete lines with random content, the
    // rest broken lines, overlong lines and noise.
    task automatic random_sequence();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65)
        begin
            send_line(line_body_len(), 1'b1);
            read_back_and_release();
        end
        else if (pick < 77)
        begin
            send_line($urandom_range(0, 8), 1'b0);
            if ($urandom_range(1) == 1)
                send_read(INDEX_W'($urandom_range(framer.length)));
        end
        else if (pick < 84)
        begin
            // At least CAPACITY body bytes: the line overflows before or at the CR.
            send_line($urandom_range(CAPACITY, CAPACITY + 8), 1'b1);
            read_back_and_release();
        end
        else
            noise_burst();
    endtask

    // Short directed part: reads and releases with nothing held, the unused
    // kind, a CR as the first byte, bytes ignored while a message is held,
    // reads at and past the length, a byte other than LF after CR, and an LF
    // as the first byte.
    task automatic directed_items();
        send_read(INDEX_W'(0));
        send_read(INDEX_W'(DEPTH - 1));
        send_release();
        send_item(KIND_UNUSED, 8'hFF, INDEX_W'(DEPTH - 1));
        send_byte(CHAR_CR);
        send_byte(8'h00);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte(8'hFF);
        send_read(INDEX_W'(0));
        send_read(INDEX_W'(3));
        send_read(INDEX_W'(4));
        send_read(INDEX_W'(DEPTH - 1));
        send_release();
        send_byte(8'h41);
        send_byte(CHAR_CR);
        send_byte(8'hFF);
        send_read(INDEX_W'(1));
        send_byte(CHAR_LF);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_release();
    endtask

    // Main sequence: reset, the directed part, then three random phases that
    // differ in how much each side idles. The first phase starts with the longest
    // line that fits, two overlong lines and a long receiver hold-off; the
    // sender pauses until everything has drained after each phase.
    initial
    begin
        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.kind       <= KIND_BYTE;
        item_ch.data_byte  <= '0;
        item_ch.read_index <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 31;
                    recv_idle_pct = 51;
                end
                1:
                begin
                    send_idle_pct = 51;
                    recv_idle_pct = 31;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (ph == 0)
            begin
                send_line(CAPACITY - 1, 1'b1);
                send_read(INDEX_W'(DEPTH - 1));
                send_release();
                send_line(CAPACITY, 1'b1);
                send_line(CAPACITY + 3, 1'b1);
                hold_request = 1'b1;
            end
            while (useful_items < ITEM_TARGET * (ph + 1) / 3)
                random_sequence();
            pause_until_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d items (%0d with effect): %0d lines framed, %0d reads checked,",
                 accepted_items, useful_items, framer.lines_framed, framer.reads_checked);
        $display("%0d lines dropped after CR and %0d overlong lines abandoned.",
                 framer.dropped_after_cr, framer.overlong_lines);
        if (framer.errors == 0 && framer.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
